// ----- src/mdc_pkg.sv -----
// ----------------------------------------------------------------------------
// mdc_pkg : shared definitions for the 3D depth-first maze carver
// Grid constants, command/action/direction codes, FSM states and the
// neighbor-choice result struct.
// ----------------------------------------------------------------------------
`default_nettype none

package mdc_pkg;

  // Grid geometry (coordinates are 4-bit fields on the ports)
  localparam int MAX_SIDE  = 16;
  localparam int COORD_W   = 4;
  localparam int CELLS     = MAX_SIDE * MAX_SIDE * MAX_SIDE;
  localparam int ROWS      = MAX_SIDE * MAX_SIDE;
  localparam int ROW_W     = $clog2(ROWS);
  localparam int STK_AW    = $clog2(CELLS);
  localparam int DEPTH_W   = STK_AW + 1;
  localparam int SIDE_W    = 5;
  localparam int NUM_DIRS  = 6;
  localparam int NUM_GRP   = 5;   // map rows fetched per step
  localparam int RAND_W    = 16;

  // Input commands
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // Result actions
  localparam logic [1:0] ACT_START  = 2'd0;
  localparam logic [1:0] ACT_CARVE  = 2'd1;
  localparam logic [1:0] ACT_BACK   = 2'd2;
  localparam logic [1:0] ACT_FINISH = 2'd3;

  // Carve directions
  localparam logic [2:0] DIR_PX = 3'd0;
  localparam logic [2:0] DIR_MX = 3'd1;
  localparam logic [2:0] DIR_PY = 3'd2;
  localparam logic [2:0] DIR_MY = 3'd3;
  localparam logic [2:0] DIR_PZ = 3'd4;
  localparam logic [2:0] DIR_MZ = 3'd5;

  // Map row fetch slots
  localparam logic [2:0] GRP_X  = 3'd0;
  localparam logic [2:0] GRP_PY = 3'd1;
  localparam logic [2:0] GRP_MY = 3'd2;
  localparam logic [2:0] GRP_PZ = 3'd3;
  localparam logic [2:0] GRP_MZ = 3'd4;

  // Control sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_RD,
    S_WAIT,
    S_PICK,
    S_CARVE,
    S_POP,
    S_DONE
  } state_t;

  // Outcome of the neighbor choice
  typedef struct packed {
    logic       any;   // at least one open neighbor
    logic [2:0] dir;   // chosen direction
  } pick_res_t;

endpackage

`default_nettype wire

// ----- src/mdc_pick.sv -----
// ----------------------------------------------------------------------------
// mdc_pick : neighbor choice
// Registers the open-neighbor mask with the scaled random index
// (random * count) >> 16, then walks the mask to the chosen direction.
// ----------------------------------------------------------------------------
`default_nettype none

module mdc_pick (
  input  wire logic                       clk,
  input  wire logic                       load,
  input  wire logic [mdc_pkg::NUM_DIRS-1:0] avail,
  input  wire logic [mdc_pkg::RAND_W-1:0]   rnd,
  output mdc_pkg::pick_res_t              res
);
  import mdc_pkg::*;

  logic [NUM_DIRS-1:0] avail_r;
  logic [2:0]          pick_r;
  logic [2:0]          cnt;
  logic [RAND_W+2:0]   prod;

  // Count open neighbors and scale the random word
  always_comb begin
    cnt = 3'd0;
    for (int i = 0; i < NUM_DIRS; i++) begin
      cnt = cnt + {2'b00, avail[i]};
    end
    prod = {3'b000, rnd} * {{RAND_W{1'b0}}, cnt};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      avail_r <= avail;
      pick_r  <= prod[RAND_W+2:RAND_W];
    end
  end

  // Find the pick_r-th set bit of the mask
  always_comb begin
    logic [2:0] seen;
    logic       hit;
    seen    = 3'd0;
    hit     = 1'b0;
    res.dir = DIR_PX;
    res.any = |avail_r;
    for (int d = 0; d < NUM_DIRS; d++) begin
      if (avail_r[d]) begin
        if (!hit && seen == pick_r) begin
          res.dir = 3'(d);
          hit     = 1'b1;
        end
        seen = seen + 3'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/maze_dfs_carver_3d.sv -----
// ----------------------------------------------------------------------------
// maze_dfs_carver_3d : randomized depth-first maze carver on a cubic grid
// Explicit cell stack and visited map held in single-port synchronous RAMs.
// ----------------------------------------------------------------------------
// A step word runs, from acceptance to a loaded result, through five
// single-port reads of the visited map (one row for both X neighbors, one
// each for +Y, -Y, +Z, -Z), a row-wait, the pick stage, the carve/pop step
// and, on a backtrack that leaves cells on the stack, one more stack read to
// refetch the new top cell; the block then returns to idle before the next
// word is taken. A step on an empty stack goes straight to loading its
// result. A start word clears the 256-row visited map one row per cycle.
// The result register lets the next word be accepted while a result is
// still waiting on out_stall. grid_side is taken from cfg_wr_data when
// cfg_wr_en is high and is clamped to 2..16 when used.
`default_nettype none

module maze_dfs_carver_3d (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // configuration
  input  wire logic                         cfg_wr_en,
  input  wire logic [mdc_pkg::SIDE_W-1:0]   cfg_wr_data,
  // input channel
  input  wire logic                         in_valid,
  output      logic                         in_stall,
  input  wire logic                         in_command,
  input  wire logic [mdc_pkg::RAND_W-1:0]   in_random_value,
  // result channel
  output      logic                         out_valid,
  input  wire logic                         out_stall,
  output      logic [1:0]                   out_action,
  output      logic [mdc_pkg::COORD_W-1:0]  out_cell_x,
  output      logic [mdc_pkg::COORD_W-1:0]  out_cell_y,
  output      logic [mdc_pkg::COORD_W-1:0]  out_cell_z,
  output      logic [2:0]                   out_direction,
  output      logic                         out_is_exit
);
  import mdc_pkg::*;

  // Control state
  state_t               state_r, state_nxt;
  logic [SIDE_W-1:0]    grid_side_r;
  logic [DEPTH_W-1:0]   depth_r;
  logic                 exit_found_r;
  logic [ROW_W-1:0]     clr_cnt_r;
  logic [2:0]           rd_cnt_r;
  logic                 rd_pend_r;
  logic [2:0]           rd_idx_r;
  logic                 out_valid_r;

  // Datapath registers
  logic [COORD_W-1:0]   top_x_r, top_y_r, top_z_r;
  logic [RAND_W-1:0]    rnd_r;
  logic [MAX_SIDE-1:0]  rows_r [NUM_GRP];
  logic [1:0]           res_act_r;
  logic [COORD_W-1:0]   res_x_r, res_y_r, res_z_r;
  logic [2:0]           res_dir_r;
  logic                 res_exit_r;
  logic [1:0]           out_act_r;
  logic [COORD_W-1:0]   out_x_r, out_y_r, out_z_r;
  logic [2:0]           out_dir_r;
  logic                 out_exit_r;

  // Memories
  logic [MAX_SIDE-1:0]  map_mem [ROWS];
  logic [MAX_SIDE-1:0]  map_q_r;
  logic [3*COORD_W-1:0] stk_mem [CELLS];
  logic [3*COORD_W-1:0] stk_q_r;

  // Memory port controls
  logic                 map_we, map_re;
  logic [ROW_W-1:0]     map_addr;
  logic [MAX_SIDE-1:0]  map_wd;
  logic                 stk_we, stk_re;
  logic [STK_AW-1:0]    stk_addr;
  logic [3*COORD_W-1:0] stk_wd;

  // Misc combinational
  logic                 in_acc;
  logic                 out_load;
  logic [SIDE_W-1:0]    side;
  logic [SIDE_W-1:0]    x5, y5, z5;
  logic [NUM_DIRS-1:0]  inb;
  logic [NUM_DIRS-1:0]  seen_bit;
  logic [NUM_DIRS-1:0]  avail;
  logic                 pick_load;
  pick_res_t            pick;
  logic [COORD_W-1:0]   nx, ny, nz;
  logic [MAX_SIDE-1:0]  base_row;
  logic                 push_ok;

  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign push_ok  = depth_r < DEPTH_W'(CELLS);

  // Effective side, clamped to 2..MAX_SIDE
  always_comb begin
    priority if (grid_side_r < SIDE_W'(2)) begin
      side = SIDE_W'(2);
    end else if (grid_side_r > SIDE_W'(MAX_SIDE)) begin
      side = SIDE_W'(MAX_SIDE);
    end else begin
      side = grid_side_r;
    end
  end

  // Neighbor bounds and visited bits
  always_comb begin
    x5 = {1'b0, top_x_r};
    y5 = {1'b0, top_y_r};
    z5 = {1'b0, top_z_r};
    inb[DIR_PX] = (x5 + SIDE_W'(1) < side) && (y5 < side) && (z5 < side);
    inb[DIR_MX] = (top_x_r != '0) && (x5 - SIDE_W'(1) < side) && (y5 < side) && (z5 < side);
    inb[DIR_PY] = (x5 < side) && (y5 + SIDE_W'(1) < side) && (z5 < side);
    inb[DIR_MY] = (top_y_r != '0) && (x5 < side) && (y5 - SIDE_W'(1) < side) && (z5 < side);
    inb[DIR_PZ] = (x5 < side) && (y5 < side) && (z5 + SIDE_W'(1) < side);
    inb[DIR_MZ] = (top_z_r != '0) && (x5 < side) && (y5 < side) && (z5 - SIDE_W'(1) < side);
    seen_bit[DIR_PX] = rows_r[GRP_X][COORD_W'(top_x_r + COORD_W'(1))];
    seen_bit[DIR_MX] = rows_r[GRP_X][COORD_W'(top_x_r - COORD_W'(1))];
    seen_bit[DIR_PY] = rows_r[GRP_PY][top_x_r];
    seen_bit[DIR_MY] = rows_r[GRP_MY][top_x_r];
    seen_bit[DIR_PZ] = rows_r[GRP_PZ][top_x_r];
    seen_bit[DIR_MZ] = rows_r[GRP_MZ][top_x_r];
    avail = inb & ~seen_bit;
  end

  // Chosen neighbor cell and the map row it lives in
  always_comb begin
    nx       = top_x_r;
    ny       = top_y_r;
    nz       = top_z_r;
    base_row = rows_r[GRP_X];
    unique case (pick.dir)
      DIR_PX: nx = top_x_r + COORD_W'(1);
      DIR_MX: nx = top_x_r - COORD_W'(1);
      DIR_PY: begin
        ny       = top_y_r + COORD_W'(1);
        base_row = rows_r[GRP_PY];
      end
      DIR_MY: begin
        ny       = top_y_r - COORD_W'(1);
        base_row = rows_r[GRP_MY];
      end
      DIR_PZ: begin
        nz       = top_z_r + COORD_W'(1);
        base_row = rows_r[GRP_PZ];
      end
      DIR_MZ: begin
        nz       = top_z_r - COORD_W'(1);
        base_row = rows_r[GRP_MZ];
      end
      default: ;
    endcase
  end

  mdc_pick u_pick (
    .clk   (clk),
    .load  (pick_load),
    .avail (avail),
    .rnd   (rnd_r),
    .res   (pick)
  );

  // Sequencer: next state and memory port controls
  always_comb begin
    state_nxt = state_r;
    in_stall  = (state_r != S_IDLE);
    pick_load = 1'b0;
    map_we    = 1'b0;
    map_re    = 1'b0;
    map_addr  = {top_z_r, top_y_r};
    map_wd    = '0;
    stk_we    = 1'b0;
    stk_re    = 1'b0;
    stk_addr  = depth_r[STK_AW-1:0];
    stk_wd    = {nz, ny, nx};
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          priority if (in_command == CMD_START) begin
            state_nxt = S_CLEAR;
          end else if (depth_r == '0) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_CLEAR: begin
        // wipe one map row per cycle, origin row keeps cell (0,0,0)
        map_we   = 1'b1;
        map_addr = clr_cnt_r;
        map_wd   = (clr_cnt_r == '0) ? MAX_SIDE'(1) : '0;
        if (clr_cnt_r == '0) begin
          stk_we   = 1'b1;
          stk_addr = '0;
          stk_wd   = '0;
        end
        if (clr_cnt_r == ROW_W'(ROWS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_RD: begin
        map_re = 1'b1;
        unique case (rd_cnt_r)
          GRP_X:  map_addr = {top_z_r, top_y_r};
          GRP_PY: map_addr = {top_z_r, COORD_W'(top_y_r + COORD_W'(1))};
          GRP_MY: map_addr = {top_z_r, COORD_W'(top_y_r - COORD_W'(1))};
          GRP_PZ: map_addr = {COORD_W'(top_z_r + COORD_W'(1)), top_y_r};
          GRP_MZ: map_addr = {COORD_W'(top_z_r - COORD_W'(1)), top_y_r};
          default: map_addr = {top_z_r, top_y_r};
        endcase
        if (rd_cnt_r == GRP_MZ) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        state_nxt = S_PICK;
      end
      S_PICK: begin
        pick_load = 1'b1;
        state_nxt = S_CARVE;
      end
      S_CARVE: begin
        if (pick.any) begin
          // mark the new cell and push it
          map_we    = 1'b1;
          map_addr  = {nz, ny};
          map_wd    = base_row | (MAX_SIDE'(1) << nx);
          stk_we    = push_ok;
          state_nxt = S_DONE;
        end else if (depth_r > DEPTH_W'(1)) begin
          // refetch the cell below the popped one
          stk_re    = 1'b1;
          stk_addr  = STK_AW'(depth_r - DEPTH_W'(2));
          state_nxt = S_POP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_POP: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_side_r  <= SIDE_W'(3);
      depth_r      <= '0;
      exit_found_r <= 1'b0;
      clr_cnt_r    <= '0;
      rd_cnt_r     <= '0;
      rd_pend_r    <= 1'b0;
      rd_idx_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        grid_side_r <= cfg_wr_data;
      end
      rd_pend_r <= (state_r == S_RD);
      rd_idx_r  <= rd_cnt_r;
      if (state_r == S_IDLE && in_acc) begin
        clr_cnt_r <= '0;
        rd_cnt_r  <= '0;
        if (in_command == CMD_START) begin
          depth_r      <= DEPTH_W'(1);
          exit_found_r <= 1'b0;
        end
      end
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + ROW_W'(1);
      end
      if (state_r == S_RD) begin
        rd_cnt_r <= rd_cnt_r + 3'd1;
      end
      if (state_r == S_CARVE) begin
        if (pick.any) begin
          if (push_ok) begin
            depth_r <= depth_r + DEPTH_W'(1);
          end
        end else begin
          depth_r      <= depth_r - DEPTH_W'(1);
          exit_found_r <= 1'b1;
        end
      end
      // result register handshake
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (rd_pend_r) begin
      rows_r[rd_idx_r] <= map_q_r;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          rnd_r      <= in_random_value;
          res_x_r    <= '0;
          res_y_r    <= '0;
          res_z_r    <= '0;
          res_dir_r  <= DIR_PX;
          res_exit_r <= 1'b0;
          if (in_command == CMD_START) begin
            res_act_r <= ACT_START;
            top_x_r   <= '0;
            top_y_r   <= '0;
            top_z_r   <= '0;
          end else begin
            res_act_r <= ACT_FINISH;
          end
        end
      end
      S_CARVE: begin
        res_x_r <= top_x_r;
        res_y_r <= top_y_r;
        res_z_r <= top_z_r;
        if (pick.any) begin
          res_act_r <= ACT_CARVE;
          res_dir_r <= pick.dir;
          if (push_ok) begin
            top_x_r <= nx;
            top_y_r <= ny;
            top_z_r <= nz;
          end
        end else begin
          res_act_r  <= ACT_BACK;
          res_exit_r <= !exit_found_r;
        end
      end
      S_POP: begin
        {top_z_r, top_y_r, top_x_r} <= stk_q_r;
      end
      default: ;
    endcase
    if (out_load) begin
      out_act_r  <= res_act_r;
      out_x_r    <= res_x_r;
      out_y_r    <= res_y_r;
      out_z_r    <= res_z_r;
      out_dir_r  <= res_dir_r;
      out_exit_r <= res_exit_r;
    end
  end

  // Visited map: 256 rows of 16 cells, row = {z, y}, bit = x
  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_addr] <= map_wd;
    end else if (map_re) begin
      map_q_r <= map_mem[map_addr];
    end
  end

  // Cell stack
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_addr] <= stk_wd;
    end else if (stk_re) begin
      stk_q_r <= stk_mem[stk_addr];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_action    = out_act_r;
  assign out_cell_x    = out_x_r;
  assign out_cell_y    = out_y_r;
  assign out_cell_z    = out_z_r;
  assign out_direction = out_dir_r;
  assign out_is_exit   = out_exit_r;

  // Stack never grows past the cell count
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_W'(CELLS))
    else $error("stack depth past cell count");

  // A carve pushes exactly one cell
  a_carve_push: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CARVE && pick.any && push_ok) |=> depth_r == $past(depth_r) + DEPTH_W'(1))
    else $error("carve did not push");

  // Exit flag only on a backtrack word, with the exit-found flag then set
  a_exit_back: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && res_exit_r) |=> (out_act_r == ACT_BACK) && exit_found_r)
    else $error("exit flag on a non-backtrack word");

  // Direction is zero unless the word reports a carve
  a_dir_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_act_r != ACT_CARVE) |-> out_dir_r == DIR_PX)
    else $error("direction set on a non-carve word");

endmodule

`default_nettype wire

// ----- verif/maze_dfs_carver_3d_test.sv -----
// ----------------------------------------------------------------------------
// maze_dfs_carver_3d_test : self-checking bench for the 3D maze carver
// Drives start and step words with random idles on both channels and
// back-pressure, predicts every result with a behavioral copy of the
// depth-first carver, and compares each accepted result word field by field.
// ----------------------------------------------------------------------------

module maze_dfs_carver_3d_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mdc_pkg::*;

  typedef struct packed {
    logic [1:0]         action;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [2:0]         dir;
    logic               is_exit;
  } carve_rec_t;

  // Behavioral carver: own visited map, cell stack and side register
  class carve_tracker;
    bit                   visited [CELLS];
    bit [3*COORD_W-1:0]   path [CELLS];
    int                   depth;
    bit                   exit_seen;
    logic [SIDE_W-1:0]    side_reg;
    carve_rec_t           carves_due [$];
    int                   errors;

    function new();
      side_reg  = 5'd3;
      depth     = 0;
      exit_seen = 1'b0;
      errors    = 0;
    endfunction

    function int pending();
      return carves_due.size();
    endfunction

    // side in force, clamped to 2..MAX_SIDE
    function int side_now();
      if (side_reg < 2) return 2;
      if (side_reg > MAX_SIDE) return MAX_SIDE;
      return int'(side_reg);
    endfunction

    function int addr(input int x, input int y, input int z);
      return x + MAX_SIDE * (y + MAX_SIDE * z);
    endfunction

    function void move_toward(input logic [2:0] code, inout int x, inout int y,
                              inout int z);
      case (code)
        DIR_PX: x++;
        DIR_MX: x--;
        DIR_PY: y++;
        DIR_MY: y--;
        DIR_PZ: z++;
        DIR_MZ: z--;
        default: ;
      endcase
    endfunction

    // Accepted input word: advance the carver and queue its result
    function void take_word(input logic cmd, input logic [RAND_W-1:0] rnd);
      carve_rec_t r;
      logic [2:0] open_dirs [NUM_DIRS];
      logic [2:0] code;
      int s, n_open, pick, cx, cy, cz, nx, ny, nz;
      r = '0;
      s = side_now();
      if (cmd == CMD_START) begin
        foreach (visited[i]) visited[i] = 1'b0;
        exit_seen  = 1'b0;
        path[0]    = '0;
        visited[0] = 1'b1;
        depth      = 1;
        r.action   = ACT_START;
      end else if (depth == 0) begin
        r.action = ACT_FINISH;
      end else begin
        {r.z, r.y, r.x} = path[depth-1];
        cx = r.x;
        cy = r.y;
        cz = r.z;
        // open neighbors in +X,-X,+Y,-Y,+Z,-Z order
        n_open = 0;
        for (int d = 0; d < NUM_DIRS; d++) begin
          code = 3'(d);
          nx = cx;
          ny = cy;
          nz = cz;
          move_toward(code, nx, ny, nz);
          if (nx >= 0 && ny >= 0 && nz >= 0 && nx < s && ny < s && nz < s &&
              !visited[addr(nx, ny, nz)]) begin
            open_dirs[n_open] = code;
            n_open++;
          end
        end
        if (n_open != 0) begin
          pick = (int'(rnd) * n_open) >> 16;
          r.dir    = open_dirs[pick];
          r.action = ACT_CARVE;
          nx = cx;
          ny = cy;
          nz = cz;
          move_toward(r.dir, nx, ny, nz);
          visited[addr(nx, ny, nz)] = 1'b1;
          if (depth < CELLS) begin
            path[depth] = {4'(nz), 4'(ny), 4'(nx)};
            depth++;
          end
        end else begin
          // dead end: pop, first one is the exit
          depth--;
          r.action  = ACT_BACK;
          r.is_exit = !exit_seen;
          exit_seen = 1'b1;
        end
      end
      carves_due.push_back(r);
    endfunction

    // Accepted result word: compare with the oldest expected carve
    function void match_result(input carve_rec_t got);
      carve_rec_t want;
      if (carves_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result word with none expected: act=%0d xyz=%0d,%0d,%0d dir=%0d",
                   $realtime, got.action, got.x, got.y, got.z, got.dir);
        return;
      end
      want = carves_due.pop_front();
      if (got.action !== want.action || got.x !== want.x || got.y !== want.y ||
          got.z !== want.z || got.dir !== want.dir || got.is_exit !== want.is_exit) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: result mismatch", $realtime);
          $display("  expected act=%0d xyz=%0d,%0d,%0d dir=%0d exit=%0d",
                   want.action, want.x, want.y, want.z, want.dir, want.is_exit);
          $display("  actual   act=%0d xyz=%0d,%0d,%0d dir=%0d exit=%0d",
                   got.action, got.x, got.y, got.z, got.dir, got.is_exit);
        end
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [SIDE_W-1:0]    cfg_wr_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_command;
  logic [RAND_W-1:0]    in_random_value;
  logic                 out_valid;
  logic                 out_stall;
  logic [1:0]           out_action;
  logic [COORD_W-1:0]   out_cell_x;
  logic [COORD_W-1:0]   out_cell_y;
  logic [COORD_W-1:0]   out_cell_z;
  logic [2:0]           out_direction;
  logic                 out_is_exit;

  carve_tracker tracker = new();
  int           words_sent;
  int           results_seen;
  int           send_calm;
  int           recv_calm;

  maze_dfs_carver_3d uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_random_value (in_random_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_action      (out_action),
    .out_cell_x      (out_cell_x),
    .out_cell_y      (out_cell_y),
    .out_cell_z      (out_cell_z),
    .out_direction   (out_direction),
    .out_is_exit     (out_is_exit)
  );

  // 8 ns clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop
  initial begin
    #(5_000_000);
    $display("DONE: errors detected");
    $finish;
  end

  // Idle length per word; now and then a run of words with no idling at all
  function automatic int idle_draw(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 11);
  endfunction

  // Random word with the extremes weighted up
  function automatic logic [RAND_W-1:0] rnd_draw();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return RAND_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Offer one input word, hold it until taken
  task automatic send_word(input logic cmd, input logic [RAND_W-1:0] rnd);
    int gap;
    gap = idle_draw(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_random_value <= rnd;
    do @(posedge clk); while (in_stall);
    tracker.take_word(cmd, rnd);
    words_sent++;
  endtask

  // Grid side write, only with the carver idle
  task automatic set_side(input logic [SIDE_W-1:0] v);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en        <= 1'b0;
    tracker.side_reg = v;
  endtask

  // Result side: random stalls, plus a few long hold-offs to back up the block
  initial begin : result_sink
    int stall_left;
    carve_rec_t got;
    out_stall <= 1'b1;
    stall_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        got = '{out_action, out_cell_x, out_cell_y, out_cell_z, out_direction,
                out_is_exit};
        tracker.match_result(got);
        results_seen++;
        stall_left = idle_draw(recv_calm);
        if (results_seen == 40 || results_seen == 200 || results_seen == 400)
          stall_left = 300;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // Stimulus
  initial begin : stimulus
    int side_val, s, n_steps;
    in_valid        <= 1'b0;
    in_command      <= CMD_START;
    in_random_value <= '0;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= '0;
    rst_n           <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: step before any start, then extremes of the random word
    send_word(CMD_STEP, 16'h1234);
    send_word(CMD_START, '1);
    send_word(CMD_STEP, '1);
    send_word(CMD_STEP, '0);
    send_word(CMD_STEP, 16'h8000);
    // shrink the grid with cells still on the stack
    set_side(5'd2);
    send_word(CMD_STEP, '0);
    send_word(CMD_STEP, '1);
    // full 2x2x2 maze, down to finished
    send_word(CMD_START, '0);
    repeat (17) send_word(CMD_STEP, rnd_draw());

    // random phases, each with its own side
    while (words_sent < 500) begin
      case ($urandom_range(0, 9))
        0: side_val = $urandom_range(0, 1);
        1: side_val = $urandom_range(16, 31);
        2: side_val = $urandom_range(0, 31);
        default: side_val = $urandom_range(2, 4);
      endcase
      set_side(SIDE_W'(side_val));
      s = tracker.side_now();
      // mostly a fresh maze; otherwise keep carving the old stack
      if ($urandom_range(0, 4) != 0) send_word(CMD_START, rnd_draw());
      n_steps = (s <= 3) ? 2 * s * s * s + 2 : $urandom_range(20, 80);
      repeat (n_steps) begin
        if ($urandom_range(0, 39) == 0) send_word(CMD_START, rnd_draw());
        else send_word(CMD_STEP, rnd_draw());
      end
    end

    // drain
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
